>>> design/brc_pkg.sv
// shared types and register codes for the blit region clip and source map block
`timescale 1ns / 1ps
`default_nettype none
package brc_pkg;

    typedef enum logic [1:0] {
        VIS_FULL    = 2'd0,
        VIS_PARTIAL = 2'd1,
        VIS_NONE    = 2'd2
    } t_vis;

    typedef enum logic {
        REG_BUFFER_WIDTH  = 1'b0,
        REG_BUFFER_HEIGHT = 1'b1
    } t_reg_index;

endpackage
`default_nettype wire

>>> design/brc_classify.sv
// classifies one rectangle against the buffer and clips it by intersection
`timescale 1ns / 1ps
`default_nettype none
module brc_classify #(
    parameter int CB = 16
) (
    input  wire logic signed [CB-1:0] i_left,
    input  wire logic signed [CB-1:0] i_top,
    input  wire logic signed [CB-1:0] i_right,
    input  wire logic signed [CB-1:0] i_bottom,
    input  wire logic        [CB-2:0] i_width,
    input  wire logic        [CB-2:0] i_height,
    output brc_pkg::t_vis             o_class,
    output logic signed      [CB-1:0] o_clip_left,
    output logic signed      [CB-1:0] o_clip_top,
    output logic signed      [CB-1:0] o_clip_right,
    output logic signed      [CB-1:0] o_clip_bottom
);
    import brc_pkg::*;

    localparam int EW = CB + 2;

    logic signed [EW-1:0] w_l, w_t, w_r, w_b, w_w, w_h;
    logic signed [EW-1:0] w_rm1, w_lw, w_bm1, w_th;
    logic                 w_full, w_ovx, w_ovy;

    // sign code: {negative, zero}
    function automatic logic [1:0] sgn_code(input logic signed [EW-1:0] v);
        sgn_code = {v[EW-1], v == '0};
    endfunction

    assign w_l = EW'(i_left);
    assign w_t = EW'(i_top);
    assign w_r = EW'(i_right);
    assign w_b = EW'(i_bottom);
    assign w_w = signed'({3'b000, i_width});
    assign w_h = signed'({3'b000, i_height});

    assign w_rm1 = w_r - EW'(1);
    assign w_lw  = w_l - w_w + EW'(1);
    assign w_bm1 = w_b - EW'(1);
    assign w_th  = w_t - w_h + EW'(1);

    assign w_full = (w_l >= 0) && (w_r <= w_w) && (w_t >= 0) && (w_b <= w_h);
    assign w_ovx  = sgn_code(w_rm1) != sgn_code(w_lw);
    assign w_ovy  = sgn_code(w_bm1) != sgn_code(w_th);

    always_comb begin
        if (w_full) begin
            o_class = VIS_FULL;
        end else if (w_ovx && w_ovy) begin
            o_class = VIS_PARTIAL;
        end else begin
            o_class = VIS_NONE;
        end
    end

    assign o_clip_left   = (w_l > 0)   ? i_left   : '0;
    assign o_clip_top    = (w_t > 0)   ? i_top    : '0;
    assign o_clip_right  = (w_r < w_w) ? i_right  : signed'({1'b0, i_width});
    assign o_clip_bottom = (w_b < w_h) ? i_bottom : signed'({1'b0, i_height});

endmodule
`default_nettype wire

>>> design/brc_div_lane.sv
// one mapping lane: signed multiply, then a restoring divider one quotient bit a stage
`timescale 1ns / 1ps
`default_nettype none
module brc_div_lane #(
    parameter int CB = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic signed [CB-1:0] i_ds,
    input  wire logic signed [CB:0]   i_dv,
    input  wire logic signed [CB:0]   i_den,
    output logic             [CB-1:0] o_q
);
    import brc_pkg::*;

    localparam int PW = 2 * CB + 1;
    localparam int DW = CB + 1;

    logic [CB-1:0] r_am;
    logic [DW-1:0] r_bm, r_dm;
    logic          r_aneg;

    logic [PW-1:0] r_q   [PW+1];
    logic [DW-1:0] r_rem [PW+1];
    logic [DW-1:0] r_d   [PW+1];
    logic          r_neg [PW+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_am   <= i_ds[CB-1] ? (~i_ds + 1'b1) : i_ds;
            r_bm   <= i_dv[CB] ? (~i_dv + 1'b1) : i_dv;
            r_dm   <= i_den[CB] ? (~i_den + 1'b1) : i_den;
            r_aneg <= i_ds[CB-1] ^ i_dv[CB] ^ i_den[CB];
            r_q[0]   <= PW'(r_am * r_bm);
            r_rem[0] <= '0;
            r_d[0]   <= r_dm;
            r_neg[0] <= r_aneg;
        end
    end

    for (genvar k = 0; k < PW; k++) begin : g_step
        logic [DW:0] w_trial;
        logic        w_ge;
        assign w_trial = {r_rem[k], r_q[k][PW-1]};
        assign w_ge    = w_trial >= {1'b0, r_d[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= w_ge ? DW'(w_trial - {1'b0, r_d[k]}) : w_trial[DW-1:0];
                r_q[k+1]   <= {r_q[k][PW-2:0], w_ge};
                r_d[k+1]   <= r_d[k];
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q <= r_neg[PW] ? (~r_q[PW][CB-1:0] + 1'b1) : r_q[PW][CB-1:0];
        end
    end

endmodule
`default_nettype wire

>>> design/blit_region_clip_and_source_map.sv
// top level: config registers, classify stage, four mapping lanes, output register
// throughput: one item per cycle unless stalled; pipelined dividers, one bit a stage
// the whole pipeline stalls only while a result waits and m_axis_tready is low
// reset (synchronous, active low) clears valid bits and both buffer sizes to zero
`timescale 1ns / 1ps
`default_nettype none
module blit_region_clip_and_source_map #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic                  i_cfg_index,
    input  wire logic [COORD_BITS-2:0] i_cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // out_left, out_top, out_right, out_bottom, vid_left, vid_top, vid_right,
    // vid_bottom, src_left, src_top, src_right, src_bottom, zero pad
    input  wire logic [((12*COORD_BITS-4+7)/8)*8-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // out_visibility, video_visibility, dst_left, dst_top, dst_right, dst_bottom,
    // map_left, map_top, map_right, map_bottom, zero pad
    output logic [((8*COORD_BITS+4+7)/8)*8-1:0] m_axis_tdata
);
    import brc_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int SW   = CB - 1;
    localparam int OW   = ((8 * CB + 4 + 7) / 8) * 8;
    localparam int LAT  = 2 * CB + 4;
    localparam int SBW  = 4 + 2 + 8 * CB - 4;

    logic [SW-1:0] r_width, r_height;
    logic          w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_BUFFER_WIDTH:  r_width  <= i_cfg_wdata;
                REG_BUFFER_HEIGHT: r_height <= i_cfg_wdata;
                default:           r_width  <= r_width;
            endcase
        end
    end

    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    // input unpack
    logic signed [CB-1:0] w_ol, w_ot, w_or, w_ob, w_vl, w_vt, w_vr, w_vb;
    logic        [SW-1:0] w_sl, w_st, w_sr, w_sb;
    assign w_ol = s_axis_tdata[0*CB +: CB];
    assign w_ot = s_axis_tdata[1*CB +: CB];
    assign w_or = s_axis_tdata[2*CB +: CB];
    assign w_ob = s_axis_tdata[3*CB +: CB];
    assign w_vl = s_axis_tdata[4*CB +: CB];
    assign w_vt = s_axis_tdata[5*CB +: CB];
    assign w_vr = s_axis_tdata[6*CB +: CB];
    assign w_vb = s_axis_tdata[7*CB +: CB];
    assign w_sl = s_axis_tdata[8*CB + 0*SW +: SW];
    assign w_st = s_axis_tdata[8*CB + 1*SW +: SW];
    assign w_sr = s_axis_tdata[8*CB + 2*SW +: SW];
    assign w_sb = s_axis_tdata[8*CB + 3*SW +: SW];

    t_vis                 w_oclass, w_vclass;
    logic signed [CB-1:0] w_ocl, w_oct, w_ocr, w_ocb;
    logic signed [CB-1:0] w_vcl, w_vct, w_vcr, w_vcb;

    brc_classify #(.CB(CB)) u_out_cls (
        .i_left(w_ol), .i_top(w_ot), .i_right(w_or), .i_bottom(w_ob),
        .i_width(r_width), .i_height(r_height),
        .o_class(w_oclass),
        .o_clip_left(w_ocl), .o_clip_top(w_oct),
        .o_clip_right(w_ocr), .o_clip_bottom(w_ocb)
    );

    brc_classify #(.CB(CB)) u_vid_cls (
        .i_left(w_vl), .i_top(w_vt), .i_right(w_vr), .i_bottom(w_vb),
        .i_width(r_width), .i_height(r_height),
        .o_class(w_vclass),
        .o_clip_left(w_vcl), .o_clip_top(w_vct),
        .o_clip_right(w_vcr), .o_clip_bottom(w_vcb)
    );

    t_vis n_vv;
    always_comb begin
        priority case (w_oclass)
            VIS_FULL: n_vv = VIS_FULL;
            VIS_NONE: n_vv = VIS_NONE;
            default:  n_vv = w_vclass;
        endcase
    end

    // classify stage register
    logic                 r_s1_valid;
    t_vis                 r_s1_ov, r_s1_vv;
    logic signed [CB-1:0] r_dl, r_dt, r_dr, r_db, r_vl, r_vt, r_vr, r_vb;
    logic        [SW-1:0] r_sl, r_st, r_sr, r_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_ov <= w_oclass;
            r_s1_vv <= n_vv;
            r_dl <= (n_vv == VIS_PARTIAL) ? w_vcl : w_vl;
            r_dt <= (n_vv == VIS_PARTIAL) ? w_vct : w_vt;
            r_dr <= (n_vv == VIS_PARTIAL) ? w_vcr : w_vr;
            r_db <= (n_vv == VIS_PARTIAL) ? w_vcb : w_vb;
            r_vl <= w_vl; r_vt <= w_vt; r_vr <= w_vr; r_vb <= w_vb;
            r_sl <= w_sl; r_st <= w_st; r_sr <= w_sr; r_sb <= w_sb;
        end
    end

    // lane operands
    logic signed [CB-1:0] w_dsx, w_dsy;
    logic signed [CB:0]   w_denx, w_deny;
    logic                 w_zx, w_zy;
    assign w_dsx  = signed'({1'b0, r_sr}) - signed'({1'b0, r_sl});
    assign w_dsy  = signed'({1'b0, r_sb}) - signed'({1'b0, r_st});
    assign w_denx = (CB+1)'(r_vr) - (CB+1)'(r_vl);
    assign w_deny = (CB+1)'(r_vb) - (CB+1)'(r_vt);
    assign w_zx   = r_vr == r_vl;
    assign w_zy   = r_vb == r_vt;

    logic [CB-1:0] w_ql, w_qt, w_qr, w_qb;

    brc_div_lane #(.CB(CB)) u_lane_l (
        .i_clk(i_clk), .i_en(w_en), .i_ds(w_dsx),
        .i_dv((CB+1)'(r_dl) - (CB+1)'(r_vl)), .i_den(w_denx), .o_q(w_ql)
    );
    brc_div_lane #(.CB(CB)) u_lane_r (
        .i_clk(i_clk), .i_en(w_en), .i_ds(w_dsx),
        .i_dv((CB+1)'(r_dr) - (CB+1)'(r_vl)), .i_den(w_denx), .o_q(w_qr)
    );
    brc_div_lane #(.CB(CB)) u_lane_t (
        .i_clk(i_clk), .i_en(w_en), .i_ds(w_dsy),
        .i_dv((CB+1)'(r_dt) - (CB+1)'(r_vt)), .i_den(w_deny), .o_q(w_qt)
    );
    brc_div_lane #(.CB(CB)) u_lane_b (
        .i_clk(i_clk), .i_en(w_en), .i_ds(w_dsy),
        .i_dv((CB+1)'(r_db) - (CB+1)'(r_vt)), .i_den(w_deny), .o_q(w_qb)
    );

    // sideband delay line matching the lane latency
    logic [SBW-1:0] r_side [LAT];
    logic           r_sbv  [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_sbv[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_sbv[0] <= r_s1_valid;
            for (int k = 1; k < LAT; k++) begin
                r_sbv[k] <= r_sbv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= {r_s1_ov, r_s1_vv, w_zx, w_zy, r_dl, r_dt, r_dr, r_db,
                          r_sl, r_st, r_sr, r_sb};
            for (int k = 1; k < LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    logic [1:0]    w_ov, w_vv;
    logic          w_ezx, w_ezy;
    logic [CB-1:0] w_edl, w_edt, w_edr, w_edb;
    logic [SW-1:0] w_esl, w_est, w_esr, w_esb;
    logic [CB-1:0] w_ml, w_mt, w_mr, w_mb;

    assign {w_ov, w_vv, w_ezx, w_ezy, w_edl, w_edt, w_edr, w_edb,
            w_esl, w_est, w_esr, w_esb} = r_side[LAT-1];

    assign w_ml = ((w_vv == VIS_PARTIAL) && !w_ezx) ? ({1'b0, w_esl} + w_ql) : {1'b0, w_esl};
    assign w_mr = ((w_vv == VIS_PARTIAL) && !w_ezx) ? ({1'b0, w_esl} + w_qr) : {1'b0, w_esr};
    assign w_mt = ((w_vv == VIS_PARTIAL) && !w_ezy) ? ({1'b0, w_est} + w_qt) : {1'b0, w_est};
    assign w_mb = ((w_vv == VIS_PARTIAL) && !w_ezy) ? ({1'b0, w_est} + w_qb) : {1'b0, w_esb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (w_en) begin
            m_axis_tvalid <= r_sbv[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            m_axis_tdata <= OW'({w_mb, w_mr, w_mt, w_ml, w_edb, w_edr, w_edt, w_edl,
                                 w_vv, w_ov});
        end
    end

`ifndef ASSERT_OFF
    a_none_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] == VIS_NONE)) |-> (m_axis_tdata[3:2] == VIS_NONE))
        else $error("video class not none for an output class of none");
    a_full_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] == VIS_FULL)) |-> (m_axis_tdata[3:2] == VIS_FULL))
        else $error("video class not full for an output class of full");
    a_partial_needs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && (r_s1_vv == VIS_PARTIAL)) |-> (r_s1_ov == VIS_PARTIAL))
        else $error("video partial while output not partial");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_s1_valid) && $stable(r_sbv[LAT-1])))
        else $error("pipeline valid moved during a stall");
`endif

endmodule
`default_nettype wire

>>> test/blit_region_clip_and_source_map_tb.sv
// self-checking bench for the blit region clip and source map block
`timescale 1ns / 1ps
`default_nettype none
module blit_region_clip_and_source_map_tb;
    import brc_pkg::*;

    localparam int CB = 16;
    localparam int IN_W = ((12*CB-4+7)/8)*8;
    localparam int OUT_W = ((8*CB+4+7)/8)*8;
    localparam int LATENCY = 2*CB + 5;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [CB-1:0] ol, ot, orr, ob, vl, vt, vr, vb;
        logic [CB-2:0] sl, st, sr, sb;
    } t_job;

    typedef struct packed {
        logic [1:0] ov, vv;
        logic [CB-1:0] dl, dt, dr, db, ml, mt, mr, mb;
    } t_clip;

    logic i_clk, i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_index;
    logic [CB-2:0] i_cfg_wdata;
    logic s_axis_tvalid, s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid, m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;

    blit_region_clip_and_source_map #(.COORD_BITS(CB)) dut (.*);

    t_job job_queue[$];
    t_clip clip_queue[$];
    int buf_w, buf_h;
    int n_fail, n_sent, n_recv, n_cycles;
    int part_count[3];
    bit calm, hold_off;
    int send_gap, recv_gap, hold_count;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // returns 0 full, 1 partial (clip written), 2 none
    function automatic int classify_rect(longint l, longint t, longint r, longint b,
                                         output longint cl, output longint ct,
                                         output longint cr, output longint cb);
        longint w, h;
        w = buf_w;
        h = buf_h;
        cl = l; ct = t; cr = r; cb = b;
        if (l >= 0 && r <= w && t >= 0 && b <= h) return 0;
        if (sign_of(r - 1) != sign_of(l - (w - 1)) && sign_of(b - 1) != sign_of(t - (h - 1))) begin
            cl = l > 0 ? l : 0;
            ct = t > 0 ? t : 0;
            cr = r < w ? r : w;
            cb = b < h ? b : h;
            return 1;
        end
        return 2;
    endfunction

    function automatic int sign_of(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic longint scale_edge(longint s1, longint s2, longint vis,
                                          longint f1, longint f2);
        return s1 + ((s2 - s1) * (vis - f1)) / (f2 - f1);
    endfunction

    function automatic t_clip predict_clip(t_job j);
        t_clip res;
        longint vl, vt, vr, vb, dl, dt, dr, db, ml, mt, mr, mb, cl, ct, cr, cb;
        int ov, vv;
        vl = j.vl; vt = j.vt; vr = j.vr; vb = j.vb;
        ov = classify_rect(j.ol, j.ot, j.orr, j.ob, cl, ct, cr, cb);
        dl = vl; dt = vt; dr = vr; db = vb;
        if (ov == 0) vv = 0;
        else if (ov == 2) vv = 2;
        else begin
            vv = classify_rect(vl, vt, vr, vb, cl, ct, cr, cb);
            if (vv == 1) begin
                dl = cl; dt = ct; dr = cr; db = cb;
            end
        end
        ml = j.sl; mt = j.st; mr = j.sr; mb = j.sb;
        if (vv == 1) begin
            if (vr != vl) begin
                ml = scale_edge(j.sl, j.sr, dl, vl, vr);
                mr = scale_edge(j.sl, j.sr, dr, vl, vr);
            end
            if (vb != vt) begin
                mt = scale_edge(j.st, j.sb, dt, vt, vb);
                mb = scale_edge(j.st, j.sb, db, vt, vb);
            end
        end
        res.ov = ov[1:0];
        res.vv = vv[1:0];
        res.dl = dl[CB-1:0]; res.dt = dt[CB-1:0]; res.dr = dr[CB-1:0]; res.db = db[CB-1:0];
        res.ml = ml[CB-1:0]; res.mt = mt[CB-1:0]; res.mr = mr[CB-1:0]; res.mb = mb[CB-1:0];
        return res;
    endfunction

    function automatic logic [IN_W-1:0] pack_job(t_job j);
        logic [IN_W-1:0] d;
        d = '0;
        d = IN_W'({j.sb, j.sr, j.st, j.sl, j.vb, j.vr, j.vt, j.vl, j.ob, j.orr, j.ot, j.ol});
        return d;
    endfunction

    // sender: next job held in tdata while tvalid is up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                clip_queue.push_back(predict_clip(job_queue.pop_front()));
                n_sent <= n_sent + 1;
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // keep offering
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(1, 10) - 1;
                s_axis_tvalid <= 1'b0;
            end else if (job_queue.size() > 0) begin
                s_axis_tdata <= pack_job(job_queue[0]);
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver with random stalls and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_gap <= 0;
        end else if (hold_off) begin
            m_axis_tready <= 1'b0;
            hold_count <= hold_count + 1;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            recv_gap <= $urandom_range(1, 10) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_clip want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            {got.mb, got.mr, got.mt, got.ml, got.db, got.dr, got.dt, got.dl, got.vv, got.ov} =
                m_axis_tdata[8*CB+3:0];
            n_recv <= n_recv + 1;
            if (clip_queue.size() == 0) begin
                $display("%0t: result with nothing expected, got %h", $time, m_axis_tdata);
                n_fail <= n_fail + 1;
            end else begin
                want = clip_queue.pop_front();
                part_count[want.vv] <= part_count[want.vv] + 1;
                if (want != got) begin
                    $display("%0t: mismatch expected ov=%0d vv=%0d dst=%h %h %h %h map=%h %h %h %h",
                             $time, want.ov, want.vv, want.dl, want.dt, want.dr, want.db,
                             want.ml, want.mt, want.mr, want.mb);
                    $display("%0t:          actual ov=%0d vv=%0d dst=%h %h %h %h map=%h %h %h %h",
                             $time, got.ov, got.vv, got.dl, got.dt, got.dr, got.db,
                             got.ml, got.mt, got.mr, got.mb);
                    n_fail <= n_fail + 1;
                end
            end
        end
    end

    function automatic logic signed [CB-1:0] rand_coord(int dim);
        case ($urandom_range(0, 9))
            0: return CB'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            2: return CB'(dim + $urandom_range(0, 4) - 2);
            3: return CB'($urandom_range(0, 4) - 2);
            default: return CB'(int'($urandom_range(0, dim + 400)) - 200);
        endcase
    endfunction

    function automatic logic [CB-2:0] rand_src();
        case ($urandom_range(0, 5))
            0: return (CB-1)'($urandom);
            1: return $urandom_range(0, 1) ? 15'h7fff : 15'h4000;
            default: return (CB-1)'($urandom_range(0, 4096));
        endcase
    endfunction

    function automatic t_job rand_job();
        t_job j;
        j.ol = rand_coord(buf_w); j.orr = rand_coord(buf_w);
        j.ot = rand_coord(buf_h); j.ob = rand_coord(buf_h);
        j.vl = rand_coord(buf_w); j.vr = rand_coord(buf_w);
        j.vt = rand_coord(buf_h); j.vb = rand_coord(buf_h);
        if ($urandom_range(0, 3) != 0) begin
            // mostly well-ordered rectangles so the clip and map paths get exercised
            if (j.ol > j.orr) {j.ol, j.orr} = {j.orr, j.ol};
            if (j.ot > j.ob) {j.ot, j.ob} = {j.ob, j.ot};
            if (j.vl > j.vr) {j.vl, j.vr} = {j.vr, j.vl};
            if (j.vt > j.vb) {j.vt, j.vb} = {j.vb, j.vt};
        end
        if ($urandom_range(0, 9) == 0) j.vr = j.vl;
        if ($urandom_range(0, 9) == 0) j.vb = j.vt;
        j.sl = rand_src(); j.st = rand_src(); j.sr = rand_src(); j.sb = rand_src();
        return j;
    endfunction

    function automatic t_job make_job(int ol, int ot, int orr, int ob,
                                      int vl, int vt, int vr, int vb,
                                      int sl, int st, int sr, int sb);
        t_job j;
        j.ol = CB'(ol); j.ot = CB'(ot); j.orr = CB'(orr); j.ob = CB'(ob);
        j.vl = CB'(vl); j.vt = CB'(vt); j.vr = CB'(vr); j.vb = CB'(vb);
        j.sl = (CB-1)'(sl); j.st = (CB-1)'(st); j.sr = (CB-1)'(sr); j.sb = (CB-1)'(sb);
        return j;
    endfunction

    task automatic drain();
        while (job_queue.size() > 0 || clip_queue.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // wr_en drops after each write, which keeps the enable updates in separate steps
    task automatic write_reg(t_reg_index idx, int value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= (CB-1)'(value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == REG_BUFFER_WIDTH) buf_w = value & 16'h7fff;
        else buf_h = value & 16'h7fff;
        @(posedge i_clk);
    endtask

    initial begin
        int sizes[6][2] = '{'{0, 0}, '{640, 480}, '{1, 1}, '{16384, 16384},
                            '{32767, 32767}, '{1920, 7}};
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0; i_cfg_index = 1'b0; i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
        n_fail = 0; n_sent = 0; n_recv = 0; n_cycles = 0;
        calm = 0; hold_off = 0; hold_count = 0;
        buf_w = 0; buf_h = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset sizes are zero: a few jobs against an empty buffer
        job_queue.push_back(make_job(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        job_queue.push_back(make_job(-5, -5, 3, 3, -2, -2, 2, 2, 0, 0, 100, 100));
        drain();
        write_reg(REG_BUFFER_WIDTH, 640);
        write_reg(REG_BUFFER_HEIGHT, 480);
        // full, partial, none, inverted, zero-size axis, extreme coordinates
        job_queue.push_back(make_job(0, 0, 640, 480, 10, 10, 20, 20, 1, 2, 3, 4));
        job_queue.push_back(make_job(-100, -50, 700, 500, -100, -50, 700, 500, 0, 0, 1600, 1000));
        job_queue.push_back(make_job(-10, 0, 100, 100, -10, 5, 50, 60, 10, 20, 130, 200));
        job_queue.push_back(make_job(-10, 0, 100, 100, 0, 0, 50, 60, 10, 20, 130, 200));
        job_queue.push_back(make_job(-10, 0, 100, 100, 700, 600, 800, 700, 1, 1, 2, 2));
        job_queue.push_back(make_job(1000, 1000, 2000, 2000, -5, -5, 5, 5, 7, 7, 9, 9));
        job_queue.push_back(make_job(-10, -10, 50, 50, 30, -20, 30, 40, 5, 6, 300, 400));
        job_queue.push_back(make_job(-10, -10, 50, 50, -20, 30, 40, 30, 5, 6, 300, 400));
        job_queue.push_back(make_job(100, 100, -100, -100, 50, 50, -50, -50, 300, 300, 0, 0));
        job_queue.push_back(make_job(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767,
                                     0, 0, 32767, 32767));
        job_queue.push_back(make_job(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767,
                                     32767, 32767, 0, 0));
        job_queue.push_back(make_job(-1, -1, 641, 481, -3000, -3000, 3000, 3000,
                                     16384, 16384, 0, 0));
        job_queue.push_back(make_job(639, 479, 640, 480, 639, 479, 641, 481, 0, 0, 32767, 32767));
        job_queue.push_back(make_job(640, 480, 641, 481, 0, 0, 1, 1, 3, 3, 4, 4));
        drain();

        foreach (sizes[k]) begin
            write_reg(REG_BUFFER_WIDTH, sizes[k][0]);
            write_reg(REG_BUFFER_HEIGHT, sizes[k][1]);
            for (int n = 0; n < 150; n++) job_queue.push_back(rand_job());
            if (k == 1) begin
                // long receiver stall while jobs keep coming
                hold_off = 1;
                while (hold_count < 300) @(posedge i_clk);
                hold_off = 0;
            end
            drain();
        end
        write_reg(REG_BUFFER_WIDTH, $urandom_range(0, 3000));
        write_reg(REG_BUFFER_HEIGHT, $urandom_range(0, 3000));
        for (int n = 0; n < 200; n++) job_queue.push_back(rand_job());
        drain();
        calm = 1;
        for (int n = 0; n < 120; n++) job_queue.push_back(rand_job());
        drain();

        $display("ran %0d jobs over nine buffer setups incl. zero and largest, %0d results",
                 n_sent, n_recv);
        $display("video class counts: full %0d, partial %0d, none %0d",
                 part_count[0], part_count[1], part_count[2]);
        if (n_fail == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
